// File: sv/lpbd_pkg.sv
package lpbd_pkg;

	localparam int FRAMES_DEF = 16;
	localparam int CFG_W      = 5;
	localparam int TABLE_W    = 10;
	localparam int PAGE_W     = 32;
	localparam int SLOT_W     = 4;
	localparam int TAG_W      = TABLE_W + PAGE_W;

	localparam logic [CFG_W-1:0] POOL_RESET = CFG_W'(16);

	typedef enum logic [3:0] {
		S_IDLE,
		S_SCAN,
		S_WALK,
		S_WNEXT,
		S_LREAD,
		S_UNLINK,
		S_PUSHA,
		S_PUSHB,
		S_DONE
	} lpbd_state_t;

	typedef struct packed {
		logic               hit;
		logic [SLOT_W-1:0]  frame_slot;
		logic               evicted;
		logic [TABLE_W-1:0] evicted_table;
		logic [PAGE_W-1:0]  evicted_page;
		logic               write_back;
		logic               no_victim;
		logic               fetch_needed;
	} lpbd_rsp_t;

endpackage

// File: sv/lpbd_req_if.sv
interface lpbd_req_if import lpbd_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               kind;
	logic [TABLE_W-1:0] tbl_id;
	logic [PAGE_W-1:0]  page_number;
	logic               mark_dirty;

	modport source (output valid, kind, tbl_id, page_number, mark_dirty, input ready);
	modport sink (input valid, kind, tbl_id, page_number, mark_dirty, output ready);
endinterface

// File: sv/lpbd_rsp_if.sv
interface lpbd_rsp_if import lpbd_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               hit;
	logic [SLOT_W-1:0]  frame_slot;
	logic               evicted;
	logic [TABLE_W-1:0] evicted_table;
	logic [PAGE_W-1:0]  evicted_page;
	logic               write_back;
	logic               no_victim;
	logic               fetch_needed;

	modport source (output valid, hit, frame_slot, evicted, evicted_table, evicted_page,
		write_back, no_victim, fetch_needed, input ready);
	modport sink (input valid, hit, frame_slot, evicted, evicted_table, evicted_page,
		write_back, no_victim, fetch_needed, output ready);
endinterface

// File: sv/lpbd_ram.sv
module lpbd_ram import lpbd_pkg::*; #(
	parameter int DEPTH = FRAMES_DEF,
	parameter int WIDTH = TAG_W
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: sv/lru_page_buffer_directory_top.sv
// A request is taken only when the directory is idle; one request is in flight at a time.
// The tag scan compares one frame a cycle and stops at the first hit or after the last frame.
// A lookup hit relinks its frame through LREAD, UNLINK, PUSHA and PUSHB, a fill through
// PUSHA and PUSHB; a victim walk passes WALK and WNEXT for each pinned frame, then relinks
// the victim like a hit. The result is loaded in DONE, which waits while a result is unread.
// Reset empties the directory at once and sets the pool size to sixteen frames.
module lru_page_buffer_directory_top import lpbd_pkg::*; #(
	parameter int MAX_FRAMES = FRAMES_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wr_en,
	input  logic [CFG_W-1:0] cfg_wr_data,
	lpbd_req_if.sink         req,
	lpbd_rsp_if.source       rsp
);

	localparam int SW = $clog2(MAX_FRAMES);
	localparam int PW = SW + 1;
	localparam int CW = $clog2(MAX_FRAMES + 1);
	localparam int KW = (CW > CFG_W) ? CW : CFG_W;
	localparam logic [PW-1:0] NIL  = {1'b1, {SW{1'b0}}};
	localparam logic [SW-1:0] LAST = SW'(MAX_FRAMES - 1);
	localparam logic [CW-1:0] MAXC = CW'(MAX_FRAMES);

	lpbd_state_t state_q, state_d;

	logic [CFG_W-1:0]      pool_q;
	logic                  kind_q;
	logic [TABLE_W-1:0]    tab_q;
	logic [PAGE_W-1:0]     pg_q;
	logic                  md_q;
	logic [CW-1:0]         cnt_q;
	logic                  cmp_vld_s1;
	logic [SW-1:0]         cmp_idx_s1;
	logic                  free_vld_q;
	logic [SW-1:0]         free_idx_q;
	logic [SW-1:0]         slot_q;
	logic [PW-1:0]         walk_q;
	logic [PW-1:0]         oldest_q;
	logic [PW-1:0]         newest_q;
	logic [CW-1:0]         used_q;
	logic [MAX_FRAMES-1:0] valid_q;
	logic [MAX_FRAMES-1:0] dirty_q;
	logic [MAX_FRAMES-1:0] pinned_q;
	lpbd_rsp_t             res_q;
	lpbd_rsp_t             out_q;
	logic                  out_vld_q;

	logic               accept;
	logic               issue;
	logic               hit_now;
	logic               last_now;
	logic [SW-1:0]      free_sel;
	logic [KW-1:0]      pool_k;
	logic [KW-1:0]      cap_k;
	logic               room;
	logic [SW-1:0]      walk_idx;
	logic               walk_nil;
	logic               walk_free;
	logic               out_load;

	logic [SW-1:0]      tag_raddr;
	logic               tag_we;
	logic [TAG_W-1:0]   tag_rdata;
	logic [SW-1:0]      nw_raddr;
	logic               nw_we;
	logic [SW-1:0]      nw_waddr;
	logic [PW-1:0]      nw_wdata;
	logic [PW-1:0]      nw_rdata;
	logic               od_we;
	logic [SW-1:0]      od_waddr;
	logic [PW-1:0]      od_wdata;
	logic [PW-1:0]      od_rdata;

	lpbd_ram #(.DEPTH(MAX_FRAMES), .WIDTH(TAG_W)) u_tag_ram (
		.clk   (clk),
		.we    (tag_we),
		.waddr (slot_q),
		.wdata ({tab_q, pg_q}),
		.raddr (tag_raddr),
		.rdata (tag_rdata)
	);

	lpbd_ram #(.DEPTH(MAX_FRAMES), .WIDTH(PW)) u_newer_ram (
		.clk   (clk),
		.we    (nw_we),
		.waddr (nw_waddr),
		.wdata (nw_wdata),
		.raddr (nw_raddr),
		.rdata (nw_rdata)
	);

	lpbd_ram #(.DEPTH(MAX_FRAMES), .WIDTH(PW)) u_older_ram (
		.clk   (clk),
		.we    (od_we),
		.waddr (od_waddr),
		.wdata (od_wdata),
		.raddr (slot_q),
		.rdata (od_rdata)
	);

	assign accept    = req.valid && req.ready;
	assign issue     = cnt_q < MAXC;
	assign hit_now   = cmp_vld_s1 && valid_q[cmp_idx_s1] && (tag_rdata == {tab_q, pg_q});
	assign last_now  = cmp_vld_s1 && (cmp_idx_s1 == LAST);
	assign free_sel  = free_vld_q ? free_idx_q : cmp_idx_s1;
	assign pool_k    = KW'(pool_q);
	assign cap_k     = (pool_k == '0) ? KW'(1) :
		((pool_k > KW'(MAX_FRAMES)) ? KW'(MAX_FRAMES) : pool_k);
	assign room      = KW'(used_q) < cap_k;
	assign walk_idx  = walk_q[SW-1:0];
	assign walk_nil  = walk_q[SW];
	assign walk_free = !walk_nil && !pinned_q[walk_idx];

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				if (hit_now) begin
					state_d = kind_q ? S_DONE : S_LREAD;
				end else if (last_now) begin
					if (kind_q) begin
						state_d = S_DONE;
					end else begin
						state_d = room ? S_PUSHA : S_WALK;
					end
				end
			end
			S_WALK: begin
				if (walk_nil) begin
					state_d = S_DONE;
				end else if (walk_free) begin
					state_d = S_LREAD;
				end else begin
					state_d = S_WNEXT;
				end
			end
			S_WNEXT:  state_d = S_WALK;
			S_LREAD:  state_d = S_UNLINK;
			S_UNLINK: state_d = S_PUSHA;
			S_PUSHA:  state_d = S_PUSHB;
			S_PUSHB:  state_d = S_DONE;
			S_DONE: begin
				if (!out_vld_q || rsp.ready) begin
					state_d = S_IDLE;
				end
			end
			default:  state_d = S_IDLE;
		endcase
	end

	always_comb begin
		req.ready = 1'b0;
		tag_raddr = cnt_q[SW-1:0];
		tag_we    = 1'b0;
		nw_raddr  = walk_idx;
		nw_we     = 1'b0;
		nw_waddr  = slot_q;
		nw_wdata  = NIL;
		od_we     = 1'b0;
		od_waddr  = slot_q;
		od_wdata  = newest_q;
		out_load  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				req.ready = 1'b1;
			end
			S_LREAD: begin
				tag_raddr = slot_q;
				nw_raddr  = slot_q;
			end
			S_UNLINK: begin
				nw_we    = !od_rdata[SW];
				nw_waddr = od_rdata[SW-1:0];
				nw_wdata = nw_rdata;
				od_we    = !nw_rdata[SW];
				od_waddr = nw_rdata[SW-1:0];
				od_wdata = od_rdata;
			end
			S_PUSHA: begin
				tag_we = res_q.fetch_needed;
				nw_we  = 1'b1;
				od_we  = 1'b1;
			end
			S_PUSHB: begin
				nw_we    = !newest_q[SW];
				nw_waddr = newest_q[SW-1:0];
				nw_wdata = {1'b0, slot_q};
			end
			S_DONE: begin
				out_load = !out_vld_q || rsp.ready;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			pool_q     <= POOL_RESET;
			used_q     <= '0;
			valid_q    <= '0;
			dirty_q    <= '0;
			pinned_q   <= '0;
			oldest_q   <= NIL;
			newest_q   <= NIL;
			out_vld_q  <= 1'b0;
			cmp_vld_s1 <= 1'b0;
			cnt_q      <= '0;
			free_vld_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			cmp_vld_s1 <= (state_q == S_SCAN) && issue;
			if (cfg_wr_en) begin
				pool_q <= cfg_wr_data;
			end
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					cnt_q      <= '0;
					free_vld_q <= 1'b0;
				end
				S_SCAN: begin
					if (issue) begin
						cnt_q <= cnt_q + CW'(1);
					end
					if (cmp_vld_s1 && !valid_q[cmp_idx_s1]) begin
						free_vld_q <= 1'b1;
					end
					if (hit_now && kind_q) begin
						pinned_q[cmp_idx_s1] <= 1'b0;
					end
				end
				S_UNLINK: begin
					if (od_rdata[SW]) begin
						oldest_q <= nw_rdata;
					end
					if (nw_rdata[SW]) begin
						newest_q <= od_rdata;
					end
				end
				S_PUSHA: begin
					pinned_q[slot_q] <= 1'b1;
					if (res_q.fetch_needed) begin
						valid_q[slot_q] <= 1'b1;
						dirty_q[slot_q] <= md_q;
						if (!res_q.evicted) begin
							used_q <= used_q + CW'(1);
						end
					end else begin
						dirty_q[slot_q] <= dirty_q[slot_q] | md_q;
					end
				end
				S_PUSHB: begin
					if (newest_q[SW]) begin
						oldest_q <= {1'b0, slot_q};
					end
					newest_q <= {1'b0, slot_q};
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		cmp_idx_s1 <= cnt_q[SW-1:0];
		if (accept) begin
			kind_q <= req.kind;
			tab_q  <= req.tbl_id;
			pg_q   <= req.page_number;
			md_q   <= req.mark_dirty;
			res_q  <= '0;
		end
		case (state_q)
			S_SCAN: begin
				if (cmp_vld_s1 && !valid_q[cmp_idx_s1] && !free_vld_q) begin
					free_idx_q <= cmp_idx_s1;
				end
				if (hit_now) begin
					slot_q           <= cmp_idx_s1;
					res_q.hit        <= 1'b1;
					res_q.frame_slot <= SLOT_W'(cmp_idx_s1);
				end else if (last_now && !kind_q) begin
					if (room) begin
						slot_q             <= free_sel;
						res_q.frame_slot   <= SLOT_W'(free_sel);
						res_q.fetch_needed <= 1'b1;
					end else begin
						walk_q <= oldest_q;
					end
				end
			end
			S_WALK: begin
				if (walk_nil) begin
					res_q.no_victim <= 1'b1;
				end else if (walk_free) begin
					slot_q             <= walk_idx;
					res_q.frame_slot   <= SLOT_W'(walk_idx);
					res_q.evicted      <= 1'b1;
					res_q.write_back   <= dirty_q[walk_idx];
					res_q.fetch_needed <= 1'b1;
				end
			end
			S_WNEXT: begin
				walk_q <= nw_rdata;
			end
			S_UNLINK: begin
				if (res_q.evicted) begin
					res_q.evicted_table <= tag_rdata[TAG_W-1:PAGE_W];
					res_q.evicted_page  <= tag_rdata[PAGE_W-1:0];
				end
			end
			default: begin
			end
		endcase
		if (out_load) begin
			out_q <= res_q;
		end
	end

	assign rsp.valid         = out_vld_q;
	assign rsp.hit           = out_q.hit;
	assign rsp.frame_slot    = out_q.frame_slot;
	assign rsp.evicted       = out_q.evicted;
	assign rsp.evicted_table = out_q.evicted_table;
	assign rsp.evicted_page  = out_q.evicted_page;
	assign rsp.write_back    = out_q.write_back;
	assign rsp.no_victim     = out_q.no_victim;
	assign rsp.fetch_needed  = out_q.fetch_needed;

	a_used_matches_valid: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_q) == int'(used_q))
		else $error("occupancy count disagrees with the valid frames");

	a_ends_agree: assert property (@(posedge clk) disable iff (!arst_n)
		oldest_q[SW] == newest_q[SW])
		else $error("recency list has only one end");

	a_walk_on_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WALK) && !walk_nil |-> valid_q[walk_idx])
		else $error("victim walk reached an empty frame");

	a_result_after_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_vld_q) |-> $past(state_q) == S_DONE)
		else $error("result raised outside the completion state");

endmodule
